// File: sv/bae_pkg.sv
// ---------------------------------------------------------------------------
// Bit array engine package
// Shared constants, operation codes and types of the bit array engine.
// ---------------------------------------------------------------------------
package bae_pkg;

  localparam int MAX_BITS   = 4096;
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  localparam int MODE_W = 4;
  localparam int POS_W  = 12;
  localparam int NSIZE_W = 13;

  localparam logic [MODE_W-1:0] MODE_READ     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SET      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_FLIP     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CLR_ALL  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SET_ALL  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_FLIP_ALL = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RESIZE   = 4'd8;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [WORD_SHIFT-1:0] bit_sel;
    logic                  bit_value;
  } wop_t;

endpackage

// File: sv/bae_in_if.sv
// ---------------------------------------------------------------------------
// Bit array engine request channel
// Valid/ready channel that carries one operation request word.
// ---------------------------------------------------------------------------
interface bae_in_if;
  logic                          valid;
  logic                          ready;
  logic [bae_pkg::MODE_W-1:0]    mode;
  logic [bae_pkg::POS_W-1:0]     position;
  logic                          bit_value;
  logic [bae_pkg::NSIZE_W-1:0]   new_size;

  modport source (output valid, mode, position, bit_value, new_size, input ready);
  modport sink (input valid, mode, position, bit_value, new_size, output ready);
endinterface

// File: sv/bae_out_if.sv
// ---------------------------------------------------------------------------
// Bit array engine result channel
// Valid/ready channel that carries one result word.
// ---------------------------------------------------------------------------
interface bae_out_if;
  logic                          valid;
  logic                          ready;
  logic                          previous_bit;
  logic                          error;
  logic [bae_pkg::NSIZE_W-1:0]   current_size;

  modport source (output valid, previous_bit, error, current_size, input ready);
  modport sink (input valid, previous_bit, error, current_size, output ready);
endinterface

// File: sv/bae_mem.sv
// ---------------------------------------------------------------------------
// Bit array word memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bae_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  bae_pkg::word_t    wdata,
  input  logic              re,
  input  logic [AddrW-1:0]  raddr,
  output bae_pkg::word_t    rdata
);

  bae_pkg::word_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bae_word_unit.sv
// ---------------------------------------------------------------------------
// Bit array word unit
// Shared modify logic: applies one operation to one stored word.
// ---------------------------------------------------------------------------
module bae_word_unit #(
  parameter int AddrW = 7,
  parameter int SizeW = 13
) (
  input  bae_pkg::wop_t     op,
  input  logic [AddrW-1:0]  word_idx,
  input  logic [SizeW-1:0]  limit,
  input  bae_pkg::word_t    rdata,
  output bae_pkg::word_t    wdata,
  output logic              prev_bit
);

  logic [SizeW-1:0] hi;
  logic [SizeW-1:0] idx_ext;
  bae_pkg::word_t   part;
  bae_pkg::word_t   lim_mask;
  bae_pkg::word_t   bit_mask;

  always_comb begin
    hi       = limit >> bae_pkg::WORD_SHIFT;
    idx_ext  = SizeW'(word_idx);
    part     = (bae_pkg::word_t'(1) << limit[bae_pkg::WORD_SHIFT-1:0]) - bae_pkg::word_t'(1);
    if (idx_ext < hi) begin
      lim_mask = '1;
    end else if (idx_ext == hi) begin
      lim_mask = part;
    end else begin
      lim_mask = '0;
    end
    bit_mask = bae_pkg::word_t'(1) << op.bit_sel;
    prev_bit = |(rdata & bit_mask);
    unique case (op.mode)
      bae_pkg::MODE_READ:     wdata = rdata;
      bae_pkg::MODE_WRITE:    wdata = op.bit_value ? (rdata | bit_mask) : (rdata & ~bit_mask);
      bae_pkg::MODE_SET:      wdata = rdata | bit_mask;
      bae_pkg::MODE_CLEAR:    wdata = rdata & ~bit_mask;
      bae_pkg::MODE_FLIP:     wdata = rdata ^ bit_mask;
      bae_pkg::MODE_CLR_ALL:  wdata = '0;
      bae_pkg::MODE_SET_ALL:  wdata = rdata | lim_mask;
      bae_pkg::MODE_FLIP_ALL: wdata = ~rdata & lim_mask;
      bae_pkg::MODE_RESIZE:   wdata = rdata & lim_mask;
      default:                wdata = rdata;
    endcase
  end

endmodule

// File: sv/bit_array_engine_unit.sv
// ---------------------------------------------------------------------------
// Bit array engine
// Variable-size bit array in 32-bit words with single-bit and whole-array
// operations, run by a small sequencer around one shared word unit.
// ---------------------------------------------------------------------------
//  channel  direction  handshake      word contents
//  in_ch    input      valid/ready    mode, position, bit_value, new_size
//  out_ch   output     valid/ready    previous_bit, error, current_size
//
// A single-bit operation starts a memory read when it is accepted, modifies and
// writes the word in the modify state, then loads the result register.
// Clear, set and flip all and a resize that changes the size walk every word
// through the memory read port, one word a cycle.
// Rejected requests and unused modes go straight to the response state.
// After reset a clearing pass over every word runs with in_ch not ready.
// A result waits in the output register while the next word is accepted; the
// sequencer holds in its response state until that register is free.
module bit_array_engine_unit #(
  parameter int MAX_BITS = bae_pkg::MAX_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  bae_in_if.sink    in_ch,
  bae_out_if.source out_ch
);

  localparam int WordCount = (MAX_BITS + bae_pkg::WORD_BITS - 1) / bae_pkg::WORD_BITS;
  localparam int AddrW     = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int SizeW     = $clog2(MAX_BITS + 1);
  localparam int CmpW      = (SizeW > bae_pkg::NSIZE_W) ? SizeW : bae_pkg::NSIZE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [AddrW:0]      ptr_r, ptr_nxt;
  logic                pend_r, pend_nxt;
  logic                need_resp_r, need_resp_nxt;
  logic [AddrW-1:0]    addr_r, addr_nxt;
  logic [SizeW-1:0]    size_r, size_nxt;
  logic [SizeW-1:0]    lim_r, lim_nxt;
  bae_pkg::wop_t       op_r, op_nxt;
  logic                res_prev_r, res_prev_nxt;
  logic                res_err_r, res_err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_prev_r, out_prev_nxt;
  logic                out_err_r, out_err_nxt;
  logic [SizeW-1:0]    out_size_r, out_size_nxt;

  logic                mem_we;
  logic                mem_re;
  logic [AddrW-1:0]    mem_raddr;
  bae_pkg::word_t      mem_rdata;
  bae_pkg::word_t      mem_wdata;
  logic                unit_prev;

  logic [bae_pkg::POS_W-1:0] pos_word;
  logic [CmpW-1:0]           pos_ext;
  logic [CmpW-1:0]           size_ext;
  logic [CmpW-1:0]           nsize_ext;
  logic                      issue;
  logic                      accept;

  bae_mem #(
    .Depth (WordCount),
    .AddrW (AddrW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bae_word_unit #(
    .AddrW (AddrW),
    .SizeW (SizeW)
  ) u_word (
    .op       (op_r),
    .word_idx (addr_r),
    .limit    (lim_r),
    .rdata    (mem_rdata),
    .wdata    (mem_wdata),
    .prev_bit (unit_prev)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.previous_bit = out_prev_r;
  assign out_ch.error        = out_err_r;
  assign out_ch.current_size = bae_pkg::NSIZE_W'(out_size_r);

  always_comb begin
    pos_word  = in_ch.position >> bae_pkg::WORD_SHIFT;
    pos_ext   = CmpW'(in_ch.position);
    size_ext  = CmpW'(size_r);
    nsize_ext = CmpW'(in_ch.new_size);
    issue     = (ptr_r < (AddrW + 1)'(WordCount));

    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    need_resp_nxt = need_resp_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    lim_nxt       = lim_r;
    op_nxt        = op_r;
    res_prev_nxt  = res_prev_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_prev_nxt  = out_prev_r;
    out_err_nxt   = out_err_r;
    out_size_nxt  = out_size_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r[AddrW-1:0];

    unique case (state_r)
      S_IDLE: begin
        mem_raddr = AddrW'(pos_word);
        if (accept) begin
          op_nxt.mode      = in_ch.mode;
          op_nxt.bit_sel   = in_ch.position[bae_pkg::WORD_SHIFT-1:0];
          op_nxt.bit_value = in_ch.bit_value;
          res_prev_nxt     = 1'b0;
          res_err_nxt      = 1'b0;
          ptr_nxt          = '0;
          pend_nxt         = 1'b0;
          need_resp_nxt    = 1'b1;
          lim_nxt          = size_r;
          state_nxt        = S_RESP;
          case (in_ch.mode) inside
            bae_pkg::MODE_READ, bae_pkg::MODE_WRITE, bae_pkg::MODE_SET,
            bae_pkg::MODE_CLEAR, bae_pkg::MODE_FLIP: begin
              if (pos_ext < size_ext) begin
                mem_re    = 1'b1;
                addr_nxt  = AddrW'(pos_word);
                state_nxt = S_MOD;
              end else begin
                res_err_nxt = 1'b1;
              end
            end
            bae_pkg::MODE_CLR_ALL, bae_pkg::MODE_SET_ALL, bae_pkg::MODE_FLIP_ALL: begin
              state_nxt = S_WALK;
            end
            bae_pkg::MODE_RESIZE: begin
              if (nsize_ext == '0 || nsize_ext > CmpW'(MAX_BITS)) begin
                res_err_nxt = 1'b1;
              end else if (nsize_ext != size_ext) begin
                lim_nxt   = (nsize_ext < size_ext) ? SizeW'(in_ch.new_size) : size_r;
                size_nxt  = SizeW'(in_ch.new_size);
                state_nxt = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        mem_we       = 1'b1;
        res_prev_nxt = unit_prev;
        state_nxt    = S_RESP;
      end
      S_WALK: begin
        mem_we   = pend_r;
        mem_re   = issue;
        pend_nxt = issue;
        if (issue) begin
          addr_nxt = ptr_r[AddrW-1:0];
          ptr_nxt  = ptr_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = need_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_prev_nxt  = res_prev_r;
          out_err_nxt   = res_err_r;
          out_size_nxt  = size_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_WALK;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      need_resp_r  <= 1'b0;
      size_r       <= SizeW'(MAX_BITS);
      op_r         <= '{mode: bae_pkg::MODE_CLR_ALL, bit_sel: '0, bit_value: 1'b0};
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      pend_r       <= pend_nxt;
      need_resp_r  <= need_resp_nxt;
      size_r       <= size_nxt;
      op_r         <= op_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r         <= addr_nxt;
    lim_r          <= lim_nxt;
    res_prev_r     <= res_prev_nxt;
    res_err_r      <= res_err_nxt;
    out_prev_r     <= out_prev_nxt;
    out_err_r      <= out_err_nxt;
    out_size_r     <= out_size_nxt;
  end

  // The current size always stays within one bit and the maximum.
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r != '0) && (CmpW'(size_r) <= CmpW'(MAX_BITS)))
    else $error("bit array size out of range");

  // A rejected request never reports a previous bit.
  a_err_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> !out_prev_r)
    else $error("error result carries a previous bit");

  // A new result is only loaded from the response state.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_RESP))
    else $error("result loaded outside the response state");

  // The walk pointer never runs beyond the word count.
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= (AddrW + 1)'(WordCount))
    else $error("walk pointer past the last word");

  // Memory writes happen only in the modify or walk states.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_MOD || (state_r == S_WALK && pend_r)))
    else $error("memory write outside a modify step");

endmodule
